/* rtl/page_buffer_slot_manager_defines.svh */
// Assertion macros for the page buffer slot manager.
// Included by the top level; no other dependencies.
`ifndef PAGE_BUFFER_SLOT_MANAGER_DEFINES_SVH
`define PAGE_BUFFER_SLOT_MANAGER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on the rising clock, off during reset
`define PBSM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on the rising clock, off during reset
`define PBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBSM_ASSERT_IMPL(lbl, ante, cons, msg)
`define PBSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/pbsm_pkg.sv */
// Shared types and constants for the page buffer slot manager.
// No dependencies.
package pbsm_pkg;

    localparam int SLOT_COUNT_DEF = 3;
    localparam int PAGE_W         = 16;
    localparam int SLOT_W         = 2;
    localparam int STAMP_W        = 32;

    localparam logic [STAMP_W-1:0] STAMP_INIT = STAMP_W'(1);
    localparam logic [STAMP_W-1:0] STAMP_MAX  = {STAMP_W{1'b1}};

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;   // latch request page, clear scan results
        logic scan;    // evaluate current slot, advance slot pointer
        logic commit;  // fill on miss, load result register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;    // slot pointer is on the last slot
    } t_dp_sts;

endpackage

/* rtl/pbsm_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on pbsm_pkg for field widths.
interface pbsm_req_if import pbsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface pbsm_rsp_if import pbsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;
    logic              hit;

    modport source (output valid, output slot_index, output hit, input ready);
    modport sink   (input valid, input slot_index, input hit, output ready);
endinterface

/* rtl/page_buffer_slot_manager.sv */
// Top level of the page buffer slot manager: controller plus datapath.
// Depends on pbsm_pkg, pbsm_if, pbsm_ctrl, pbsm_dp and the defines header.
//
//   channel  dir  payload                 handshake
//   i_req    in   page_number[15:0]       valid / ready
//   o_rsp    out  slot_index[1:0], hit    valid / ready
//
// A request is accepted, then the slot table is scanned slot by slot through
// a single comparator, then the fill is committed and the result register
// loaded.
// The result register frees the input side: the next request is accepted
// while a response still waits. Commit stalls only if that register is full.
// Reset clears the valid bits and sets the load counter to one; no sweep.
`include "page_buffer_slot_manager_defines.svh"

module page_buffer_slot_manager import pbsm_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbsm_req_if.sink   i_req,
    pbsm_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pbsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    pbsm_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_page_number (i_req.page_number),
        .o_sts         (sts),
        .o_slot_index  (o_rsp.slot_index),
        .o_hit         (o_rsp.hit)
    );

    // An accepted beat starts a scan on the next cycle
    `PBSM_ASSERT_NEXT(a_accept_scan, i_req.valid && i_req.ready, cmd.scan, "scan did not start")
    // No request is taken while a scan runs
    `PBSM_ASSERT_IMPL(a_scan_busy, cmd.scan, !i_req.ready, "request taken during scan")
    // Commit never overwrites a stalled response
    `PBSM_ASSERT_IMPL(a_no_overwrite, o_rsp.valid && !o_rsp.ready, !cmd.commit,
                      "response overwritten")
    // A commit always presents a response
    `PBSM_ASSERT_NEXT(a_commit_valid, cmd.commit, o_rsp.valid, "commit without response")

endmodule

/* rtl/pbsm_ctrl.sv */
// Controller for the page buffer slot manager: sequences accept, scan, commit.
// Depends on pbsm_pkg.
module pbsm_ctrl import pbsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        // drop the result once the sink takes the beat
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/pbsm_dp.sv */
// Datapath for the page buffer slot manager: slot table, scan unit, result register.
// Depends on pbsm_pkg.
module pbsm_dp import pbsm_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [PAGE_W-1:0] i_page_number,
    output t_dp_sts           o_sts,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic              o_hit
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    // Slot table
    logic [SLOT_COUNT-1:0] r_valid;
    logic [PAGE_W-1:0]     r_page  [SLOT_COUNT];
    logic [STAMP_W-1:0]    r_stamp [SLOT_COUNT];
    logic [STAMP_W-1:0]    r_counter;

    // Scan state
    logic [IDX_W-1:0]   r_k;
    logic [PAGE_W-1:0]  r_req_page;
    logic               r_hit_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   r_best_idx;
    logic [STAMP_W-1:0] r_best_stamp;

    // Result register
    logic [SLOT_W-1:0]  r_slot_index;
    logic               r_hit;

    logic               cur_valid;
    logic [PAGE_W-1:0]  cur_page;
    logic [STAMP_W-1:0] cur_stamp;
    logic [IDX_W-1:0]   victim;

    // Read the slot under the pointer
    assign cur_valid = r_valid[r_k];
    assign cur_page  = r_page[r_k];
    assign cur_stamp = r_stamp[r_k];

    // Free slot wins over the oldest stamp
    assign victim = r_free_found ? r_free_idx : r_best_idx;

    assign o_sts.last = (r_k == IDX_LAST);

    // Control state: valid bits and load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= STAMP_INIT;
        end else if (i_cmd.commit && !r_hit_found) begin
            r_valid[victim] <= 1'b1;
            if (r_counter != STAMP_MAX) begin
                r_counter <= r_counter + STAMP_W'(1);
            end
        end
    end

    // Scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k          <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_k          <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (!o_sts.last) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (cur_valid && (cur_page == r_req_page) && !r_hit_found) begin
                r_hit_found <= 1'b1;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // Scan payload: keep lowest hit, lowest free, strictly oldest stamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_page <= i_page_number;
        end
        if (i_cmd.scan) begin
            if (cur_valid && (cur_page == r_req_page) && !r_hit_found) begin
                r_hit_idx <= r_k;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_idx <= r_k;
            end
            if ((r_k == '0) || (cur_stamp < r_best_stamp)) begin
                r_best_idx   <= r_k;
                r_best_stamp <= cur_stamp;
            end
        end
    end

    // Fill the victim on a miss and load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_hit_found) begin
                r_slot_index <= SLOT_W'(r_hit_idx);
                r_hit        <= 1'b1;
            end else begin
                r_page[victim]  <= r_req_page;
                r_stamp[victim] <= r_counter;
                r_slot_index    <= SLOT_W'(victim);
                r_hit           <= 1'b0;
            end
        end
    end

    assign o_slot_index = r_slot_index;
    assign o_hit        = r_hit;

endmodule
